// File: hw/rtl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// shared types and constants of the serial frame decoder
// ----------------------------------------------------------------------------
package sfd_pkg;

  // frame layout
  localparam int FRAME_BYTES  = 25;
  localparam int NUM_CHANNELS = 16;
  localparam int CHANNEL_BITS = 11;
  // bytes 1 to 23 are kept: channel data and the flag byte
  localparam int RX_BITS      = (FRAME_BYTES - 2) * 8;
  localparam int DATA_BITS    = NUM_CHANNELS * CHANNEL_BITS;

  typedef logic [7:0]              byte_t;
  typedef logic [4:0]              chan_num_t;
  typedef logic [CHANNEL_BITS-1:0] chan_val_t;
  typedef logic [4:0]              pos_t;

  localparam byte_t     HEADER_BYTE  = 8'h0F;
  localparam byte_t     GAP_BYTE     = 8'h00;
  localparam byte_t     PREV_RESET   = 8'hAA;
  localparam byte_t     MASK_RESET   = 8'h08;
  localparam pos_t      FIRST_POS    = 5'd1;
  localparam pos_t      LAST_POS     = 5'(FRAME_BYTES - 1);
  localparam chan_num_t FLAG_CHANNEL = 5'(NUM_CHANNELS);

  // configuration port
  localparam int ADDR_W = 3;
  typedef logic [ADDR_W-3:0] reg_idx_t;
  localparam reg_idx_t REG_DISCONNECT_MASK = '0;

endpackage

// File: hw/rtl/sfd_ifs.sv
// ----------------------------------------------------------------------------
// sfd channel interfaces
// valid/ready channels for received bytes and for decoded results
// ----------------------------------------------------------------------------
interface sfd_rx_if;
  import sfd_pkg::*;

  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_res_if;
  import sfd_pkg::*;

  logic      valid;
  logic      ready;
  chan_num_t channel_number;
  chan_val_t channel_value;
  logic      link_ok;
  logic      last;

  modport source (output valid, output channel_number, output channel_value,
                  output link_ok, output last, input ready);
  modport sink   (input valid, input channel_number, input channel_value,
                  input link_ok, input last, output ready);
endinterface

// File: hw/rtl/sbus_frame_decoder.sv
// ----------------------------------------------------------------------------
// sbus_frame_decoder
// 25-byte serial frame decoder: header hunt, byte collection, unpacking of
// sixteen 11-bit channels and the flag byte into 17 result transactions
// ----------------------------------------------------------------------------
// the first result is valid the cycle after the footer byte is accepted
// bytes are taken one per cycle, save the footer wait below; results leave
//   one per cycle from an unload shift register while the sink is ready
// the footer byte waits only while the previous frame's results are unsent
// reset (rst, synchronous): hunting, previous byte 0xAA, mask 0x08, no results
// ----------------------------------------------------------------------------
module sbus_frame_decoder (
  input  logic                         clk,
  input  logic                         rst,
  sfd_rx_if.sink                       rx,
  sfd_res_if.source                    res,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sfd_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import sfd_pkg::*;

  // receive side state
  byte_t                previous_byte;
  logic                 in_frame;
  pos_t                 byte_position;
  logic                 just_finished;
  // bytes 1..23 of the current frame, newest byte enters at the top
  logic [RX_BITS-1:0]   rx_data;

  // result side state
  logic                 emit_busy;
  chan_num_t            emit_cnt;
  logic [DATA_BITS-1:0] emit_bits;
  byte_t                flags;
  logic                 ok;

  byte_t                disconnect_mask;

  logic     rx_acc;
  logic     res_acc;
  logic     at_footer;
  logic     hdr_ok;
  logic     frame_done;
  logic     cfg_wr;
  reg_idx_t reg_idx;
  byte_t    new_flags;

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_DISCONNECT_MASK) begin
      prdata = {24'd0, disconnect_mask};
    end
  end

  // --------------------------------------------------------------------------
  // handshakes
  // --------------------------------------------------------------------------
  assign rx_acc     = rx.valid && rx.ready;
  assign res_acc    = res.valid && res.ready;
  assign at_footer  = in_frame && (byte_position == LAST_POS);
  // the footer byte loads the unload register, so it waits for it to drain
  assign rx.ready   = !(at_footer && emit_busy);
  assign frame_done = rx_acc && at_footer;

  // a header counts after a gap byte, or straight after the previous frame
  assign hdr_ok = (rx.rx_byte == HEADER_BYTE) &&
                  ((previous_byte == GAP_BYTE) || just_finished);

  assign new_flags = rx_data[RX_BITS-1 -: 8];

  // --------------------------------------------------------------------------
  // control state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_byte   <= PREV_RESET;
      in_frame        <= 1'b0;
      byte_position   <= '0;
      just_finished   <= 1'b0;
      disconnect_mask <= MASK_RESET;
      emit_busy       <= 1'b0;
      emit_cnt        <= '0;
    end else begin
      if (cfg_wr && (reg_idx == REG_DISCONNECT_MASK)) begin
        disconnect_mask <= pwdata[7:0];
      end

      if (rx_acc) begin
        if (!in_frame) begin
          // hunting: a rejected header is just another byte
          if (hdr_ok) begin
            in_frame      <= 1'b1;
            byte_position <= FIRST_POS;
          end else begin
            previous_byte <= rx.rx_byte;
          end
          just_finished <= 1'b0;
        end else if (at_footer) begin
          // footer is taken but not checked
          in_frame      <= 1'b0;
          byte_position <= '0;
          just_finished <= 1'b1;
        end else begin
          byte_position <= byte_position + 5'd1;
        end
      end

      if (frame_done) begin
        emit_busy <= 1'b1;
        emit_cnt  <= '0;
      end else if (res_acc) begin
        if (emit_cnt == FLAG_CHANNEL) begin
          emit_busy <= 1'b0;
        end else begin
          emit_cnt <= emit_cnt + 5'd1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rx_acc && in_frame && !at_footer) begin
      rx_data <= {rx.rx_byte, rx_data[RX_BITS-1:8]};
    end

    if (frame_done) begin
      // channel bits run little-endian from byte 1 bit 0
      emit_bits <= rx_data[DATA_BITS-1:0];
      flags     <= new_flags;
      ok        <= ((new_flags & disconnect_mask) == '0);
    end else if (res_acc) begin
      emit_bits <= emit_bits >> CHANNEL_BITS;
    end
  end

  // --------------------------------------------------------------------------
  // result channel
  // --------------------------------------------------------------------------
  assign res.valid          = emit_busy;
  assign res.channel_number = emit_cnt;
  assign res.channel_value  = (emit_cnt == FLAG_CHANNEL) ?
                              {3'd0, flags} : emit_bits[CHANNEL_BITS-1:0];
  assign res.link_ok        = ok;
  assign res.last           = (emit_cnt == FLAG_CHANNEL);

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // a frame never ends while the previous one is still unloading
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    frame_done |-> !emit_busy)
    else $error("frame ended while results still pending");

  // a finished frame starts its results with channel 0
  a_unload_start: assert property (@(posedge clk) disable iff (rst)
    frame_done |=> (res.valid && (res.channel_number == '0)))
    else $error("results did not start at channel 0");

  // position tracks the framing state
  a_position: assert property (@(posedge clk) disable iff (rst)
    (in_frame && (byte_position >= FIRST_POS) && (byte_position <= LAST_POS)) ||
    (!in_frame && (byte_position == '0)))
    else $error("byte position out of step with framing");

  // the unload counter stays within the 17 results
  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    emit_busy |-> (emit_cnt <= FLAG_CHANNEL))
    else $error("result counter past flag result");

endmodule
